[rtl/lpht_pkg.sv]
package lpht_pkg;

   // table geometry
   localparam int TABLE_SLOTS = 16;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
   localparam bit IS_POW2     = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

   // field widths
   localparam int KEY_W     = 31;
   localparam int VALUE_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int LIVE_W    = 5;

   // slot marks
   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_USED  = 2'd1;
   localparam logic [1:0] MARK_GONE  = 2'd2;

   // operations
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

   // sequencer step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_HOME      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_LOAD      = 4'd2;
   localparam logic [STEP_W-1:0] STEP_INS_PROBE = 4'd3;
   localparam logic [STEP_W-1:0] STEP_INS_NEW   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_INS_UPD   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_INS_FULL  = 4'd6;
   localparam logic [STEP_W-1:0] STEP_RM_PROBE  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_RM_HIT    = 4'd8;
   localparam logic [STEP_W-1:0] STEP_RM_MISS   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_RM_SPARE  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_FINISH    = 4'd11;
   localparam logic [STEP_W-1:0] STEP_DONE      = 4'd12;
   localparam logic [STEP_W-1:0] STEP_CLEAR     = 4'd13;
   localparam logic [STEP_W-1:0] STEP_POST_CLR  = 4'd14;

   // jump modes
   localparam logic [1:0] JM_SEQ  = 2'd0;
   localparam logic [1:0] JM_GOTO = 2'd1;
   localparam logic [1:0] JM_IF   = 2'd2;
   localparam logic [1:0] JM_DISP = 2'd3;

   // jump conditions
   localparam logic [2:0] C_REQ_WAIT   = 3'd0;
   localparam logic [2:0] C_HOME_WAIT  = 3'd1;
   localparam logic [2:0] C_OP_REMOVE  = 3'd2;
   localparam logic [2:0] C_RSP_BUSY   = 3'd3;
   localparam logic [2:0] C_CLEAR_MORE = 3'd4;

   // memory write kinds
   localparam logic [1:0] WR_NONE  = 2'd0;
   localparam logic [1:0] WR_FILL  = 2'd1;
   localparam logic [1:0] WR_TOMB  = 2'd2;
   localparam logic [1:0] WR_CLEAR = 2'd3;

   // live count operations
   localparam logic [1:0] CNT_KEEP = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;

   // probe outcomes, added to the dispatch base
   localparam logic [1:0] OUT_GO = 2'd0;
   localparam logic [1:0] OUT_A  = 2'd1;
   localparam logic [1:0] OUT_B  = 2'd2;
   localparam logic [1:0] OUT_C  = 2'd3;

   typedef struct packed {
      logic [1:0]          mark;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } slot_type;

   typedef struct packed {
      logic [1:0]          jump_mode;
      logic [2:0]          cond;
      logic [STEP_W-1:0]   target;
      logic                req_ready;
      logic                load_home;
      logic                probe_ins;
      logic                probe_rm;
      logic [1:0]          wr_kind;
      logic [1:0]          cnt_op;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                rsp_load;
   } ctl_type;

   typedef struct packed {
      logic       req_wait;
      logic       home_wait;
      logic       op_remove;
      logic       rsp_busy;
      logic       clear_more;
      logic [1:0] outcome;
   } stat_type;

   // microcode store
   function automatic ctl_type prog_word(logic [STEP_W-1:0] step);
      ctl_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.jump_mode = JM_IF;  w.cond = C_REQ_WAIT;  w.target = STEP_IDLE;
            w.req_ready = 1'b1;
         end
         STEP_HOME: begin
            w.jump_mode = JM_IF;  w.cond = C_HOME_WAIT; w.target = STEP_HOME;
         end
         STEP_LOAD: begin
            w.jump_mode = JM_IF;  w.cond = C_OP_REMOVE; w.target = STEP_RM_PROBE;
            w.load_home = 1'b1;
         end
         STEP_INS_PROBE: begin
            w.jump_mode = JM_DISP; w.target = STEP_INS_PROBE;
            w.probe_ins = 1'b1;
         end
         STEP_INS_NEW: begin
            w.jump_mode = JM_GOTO; w.target = STEP_FINISH;
            w.wr_kind = WR_FILL; w.cnt_op = CNT_INC;
            w.set_status = 1'b1; w.status = ST_INSERTED;
         end
         STEP_INS_UPD: begin
            w.jump_mode = JM_GOTO; w.target = STEP_FINISH;
            w.wr_kind = WR_FILL;
            w.set_status = 1'b1; w.status = ST_UPDATED;
         end
         STEP_INS_FULL: begin
            w.jump_mode = JM_GOTO; w.target = STEP_FINISH;
            w.set_status = 1'b1; w.status = ST_FULL;
         end
         STEP_RM_PROBE: begin
            w.jump_mode = JM_DISP; w.target = STEP_RM_PROBE;
            w.probe_rm = 1'b1;
         end
         STEP_RM_HIT: begin
            w.jump_mode = JM_GOTO; w.target = STEP_FINISH;
            w.wr_kind = WR_TOMB; w.cnt_op = CNT_DEC;
            w.set_status = 1'b1; w.status = ST_REMOVED;
         end
         STEP_RM_MISS, STEP_RM_SPARE: begin
            w.jump_mode = JM_GOTO; w.target = STEP_FINISH;
            w.set_status = 1'b1; w.status = ST_MISSING;
         end
         STEP_FINISH: begin
            w.jump_mode = JM_IF;  w.cond = C_RSP_BUSY; w.target = STEP_FINISH;
            w.rsp_load = 1'b1;
         end
         STEP_CLEAR: begin
            w.jump_mode = JM_IF;  w.cond = C_CLEAR_MORE; w.target = STEP_CLEAR;
            w.wr_kind = WR_CLEAR;
         end
         STEP_DONE, STEP_POST_CLR: begin
            w.jump_mode = JM_GOTO; w.target = STEP_IDLE;
         end
         default: begin
            w.jump_mode = JM_GOTO; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[rtl/lpht_req_if.sv]
interface lpht_req_if import lpht_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [KEY_W-1:0]          key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, operation, key, value, input ready);
   modport sink   (input valid, operation, key, value, output ready);
endinterface

[rtl/lpht_rsp_if.sv]
interface lpht_rsp_if import lpht_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [LIVE_W-1:0]   live_count;

   modport source (output valid, status, live_count, input ready);
   modport sink   (input valid, status, live_count, output ready);
endinterface

[rtl/linear_probe_hash_table.sv]
// Open-addressing key/value table with linear probing over TABLE_SLOTS slots
// (16 here). Each request inserts/updates a key with a value, or removes a key,
// and gives exactly one response with a status and the live entry count. After
// reset a clearing pass marks every slot empty, one slot a cycle, before the
// first request is taken. A request probes 1 to TABLE_SLOTS slots, and the
// probe reads one slot per cycle: the slot memory has a single registered read
// port. With a table size that is not a power of two, the home slot comes from
// a reciprocal multiplication, held in a product register and then in a
// remainder register. A response waits in an output register; the next request
// is accepted only once the previous one has been handed to that register.
module linear_probe_hash_table import lpht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lpht_req_if.sink   req,
   lpht_rsp_if.source rsp
);

   // control word from the microcode store, flags back from the datapath
   ctl_type  ctl;
   stat_type stat;

   // step counter, microcode store and jump logic
   lpht_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   // slot memory, probe pointer, home slot unit, count and response register
   lpht_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

[rtl/lpht_sequencer.sv]
module lpht_sequencer import lpht_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctl_type  ctl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              cond_true;

   assign ctl = prog_word(step_ff);

   always_comb begin
      unique case (ctl.cond)
         C_REQ_WAIT:   cond_true = stat.req_wait;
         C_HOME_WAIT:  cond_true = stat.home_wait;
         C_OP_REMOVE:  cond_true = stat.op_remove;
         C_RSP_BUSY:   cond_true = stat.rsp_busy;
         C_CLEAR_MORE: cond_true = stat.clear_more;
         default:      cond_true = 1'b0;
      endcase
   end

   always_comb begin
      unique case (ctl.jump_mode)
         JM_SEQ:  step_in = step_ff + 1'b1;
         JM_GOTO: step_in = ctl.target;
         JM_IF:   step_in = cond_true ? ctl.target : step_ff + 1'b1;
         JM_DISP: step_in = ctl.target + STEP_W'(stat.outcome);
         default: step_in = STEP_IDLE;
      endcase
   end

   // reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

[rtl/lpht_datapath.sv]
module lpht_datapath import lpht_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  ctl_type   ctl,
   output stat_type  stat,
   lpht_req_if.sink  req,
   lpht_rsp_if.source rsp
);

   localparam int CNT_EXT_W = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

   slot_type mem [TABLE_SLOTS];
   slot_type rd_ff;
   slot_type wr_data;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;
   logic              wr_en;

   logic                      op_ff;
   logic [KEY_W-1:0]          key_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic [SLOT_W-1:0]         slot_next;
   logic [SLOT_W-1:0]         home;
   logic                      home_busy;
   logic [SLOT_W-1:0]         clear_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [STATUS_W-1:0]       status_ff;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [LIVE_W-1:0]         rsp_live_ff;
   logic [CNT_EXT_W-1:0]      count_ext;
   logic                      accept;
   logic                      rsp_busy;
   logic                      used, hit, wrap;
   logic [1:0]                ins_out, rm_out, outcome;
   logic                      advance;

   assign req.ready = ctl.req_ready;
   assign accept    = req.valid && ctl.req_ready;

   // request latch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req.operation;
         key_ff   <= req.key;
         value_ff <= req.value;
      end
   end

   // home slot: mask, or a registered reciprocal multiplication
   if (IS_POW2) begin : g_home_mask
      assign home      = key_ff[SLOT_W-1:0];
      assign home_busy = 1'b0;
   end else begin : g_home_recip
      // rounded-up reciprocal, exact quotient for every key of width KEY_W
      localparam int          RECIP_SH = KEY_W + SLOT_W;
      localparam logic [31:0] RECIP    =
         32'(((64'd1 << RECIP_SH) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));

      logic [1:0]         stage_ff;
      logic [KEY_W+31:0]  prod_ff;
      logic [KEY_W-1:0]   quot;
      logic [KEY_W-1:0]   rem_full;
      logic [SLOT_W-1:0]  rem_ff;

      assign quot     = KEY_W'(prod_ff >> RECIP_SH);
      assign rem_full = key_ff - quot * KEY_W'(TABLE_SLOTS);

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff <= '0;
         end else if (accept) begin
            stage_ff <= 2'b01;
         end else begin
            stage_ff <= {stage_ff[0], 1'b0};
         end
      end

      // stage_ff[0] multiplies into prod_ff, stage_ff[1] takes the remainder into rem_ff
      always_ff @(posedge clock) begin
         if (stage_ff[0]) begin
            prod_ff <= (KEY_W + 32)'(key_ff) * (KEY_W + 32)'(RECIP);
         end
         if (stage_ff[1]) begin
            rem_ff <= rem_full[SLOT_W-1:0];
         end
      end

      assign home      = rem_ff;
      assign home_busy = stage_ff != 2'b00;
   end

   // probe evaluation on the slot just read
   assign slot_next = (slot_ff == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
   assign used      = rd_ff.mark == MARK_USED;
   assign hit       = used && rd_ff.key == key_ff;
   assign wrap      = slot_next == home;

   always_comb begin
      priority if (!used) begin
         ins_out = OUT_A;
      end else if (hit) begin
         ins_out = OUT_B;
      end else if (wrap) begin
         ins_out = OUT_C;
      end else begin
         ins_out = OUT_GO;
      end
   end

   always_comb begin
      priority if (rd_ff.mark == MARK_EMPTY) begin
         rm_out = OUT_B;
      end else if (hit) begin
         rm_out = OUT_A;
      end else if (wrap) begin
         rm_out = OUT_B;
      end else begin
         rm_out = OUT_GO;
      end
   end

   assign outcome = ctl.probe_rm ? rm_out : ins_out;
   assign advance = (ctl.probe_ins || ctl.probe_rm) && outcome == OUT_GO;

   always_comb begin
      priority if (ctl.load_home) begin
         slot_in = home;
      end else if (advance) begin
         slot_in = slot_next;
      end else begin
         slot_in = slot_ff;
      end
   end

   assign rd_addr = slot_in;

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // slot memory write port
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = slot_ff;
      wr_data = rd_ff;
      unique case (ctl.wr_kind)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_FILL: begin
            wr_data = '{mark: MARK_USED, key: key_ff, value: value_ff};
         end
         WR_TOMB: begin
            wr_data.mark = MARK_GONE;
         end
         WR_CLEAR: begin
            wr_addr      = clear_ff;
            wr_data.mark = MARK_EMPTY;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= '0;
      end else if (ctl.wr_kind == WR_CLEAR) begin
         clear_ff <= clear_ff + 1'b1;
      end
   end

   // live entry count
   always_comb begin
      unique case (ctl.cnt_op)
         CNT_INC: count_in = count_ff + 1'b1;
         CNT_DEC: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.set_status) begin
         status_ff <= ctl.status;
      end
   end

   // response register
   assign rsp_busy  = rsp_valid_ff && !rsp.ready;
   assign count_ext = CNT_EXT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.rsp_load && !rsp_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rsp_load && !rsp_busy) begin
         rsp_status_ff <= status_ff;
         rsp_live_ff   <= count_ext[LIVE_W-1:0];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.live_count = rsp_live_ff;

   assign stat.req_wait   = !accept;
   assign stat.home_wait  = home_busy;
   assign stat.op_remove  = op_ff == OP_REMOVE;
   assign stat.rsp_busy   = rsp_busy;
   assign stat.clear_more = clear_ff != SLOT_W'(TABLE_SLOTS - 1);
   assign stat.outcome    = outcome;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_SLOTS))
      else $error("live count beyond table size");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      ctl.cnt_op == CNT_INC |-> count_ff < CNT_W'(TABLE_SLOTS))
      else $error("insert into a table with no free slot");

   a_tomb_on_match: assert property (@(posedge clock) disable iff (reset)
      ctl.wr_kind == WR_TOMB |-> (rd_ff.mark == MARK_USED && rd_ff.key == key_ff))
      else $error("tombstone written over a slot that does not match");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import lpht_pkg::*;

   // one expected response, as the table should answer a request
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [LIVE_W-1:0]   live_count;
   } reply_type;

   logic clock;
   logic reset;

   lpht_req_if req_ch ();
   lpht_rsp_if rsp_ch ();

   linear_probe_hash_table dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // shadow copy of the slot store, updated as each request is accepted
   logic [1:0]         shadow_mark  [TABLE_SLOTS];
   logic [KEY_W-1:0]   shadow_key   [TABLE_SLOTS];
   logic [VALUE_W-1:0] shadow_value [TABLE_SLOTS];
   int unsigned        shadow_live;

   // responses still owed by the table, oldest first
   reply_type pending_replies [$];

   bit idle_on;
   int error_count;
   int sent_count;
   int checked_count;
   int status_tally [8];

   // free-running clock, 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard limit on the run, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

   // works out status and live count for one request and applies it to the shadow table
   function automatic reply_type table_outcome(input logic op, input logic [KEY_W-1:0] k,
                                               input logic [VALUE_W-1:0] v);
      reply_type   r;
      int unsigned home;
      int unsigned s;
      int unsigned n;
      bit          done;
      home = k % TABLE_SLOTS;
      done = 1'b0;
      if (op == OP_INSERT) begin
         // a full lap over occupied slots without the key means the table is full
         r.status = ST_FULL;
         for (n = 0; n < TABLE_SLOTS && !done; n++) begin
            s = (home + n) % TABLE_SLOTS;
            if (shadow_mark[s] != MARK_USED) begin
               // first empty or tombstoned slot wins, even if the key sits further on
               shadow_mark[s]  = MARK_USED;
               shadow_key[s]   = k;
               shadow_value[s] = v;
               shadow_live++;
               r.status = ST_INSERTED;
               done = 1'b1;
            end else if (shadow_key[s] == k) begin
               shadow_value[s] = v;
               r.status = ST_UPDATED;
               done = 1'b1;
            end
         end
      end else begin
         // walk until an empty slot, stepping over tombstones, at most one lap
         r.status = ST_MISSING;
         for (n = 0; n < TABLE_SLOTS && !done; n++) begin
            s = (home + n) % TABLE_SLOTS;
            if (shadow_mark[s] == MARK_EMPTY) begin
               done = 1'b1;
            end else if (shadow_mark[s] == MARK_USED && shadow_key[s] == k) begin
               shadow_mark[s] = MARK_GONE;
               shadow_live--;
               r.status = ST_REMOVED;
               done = 1'b1;
            end
         end
      end
      r.live_count = LIVE_W'(shadow_live);
      return r;
   endfunction

   task automatic log_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("tb_top: mismatch: %s", msg);
      end
   endtask

   // drives one request, with a random gap in front, and books its expected response
   task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                               input logic [VALUE_W-1:0] v);
      while (idle_on && $urandom_range(99) < 21) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.key       <= k;
      req_ch.value     <= v;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_replies.push_back(table_outcome(op, k, v));
      sent_count++;
   endtask

   // response side back-pressure, ready dropped at random about 21 percent of the time while idle_on is set
   always @(posedge clock) begin
      rsp_ch.ready <= !(idle_on && $urandom_range(99) < 21);
   end

   // response checker, compares each handshake against the oldest expectation
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         checked_count++;
         status_tally[rsp_ch.status]++;
         if (pending_replies.size() == 0) begin
            log_error($sformatf("response with no request outstanding: status %0d live %0d",
                                rsp_ch.status, rsp_ch.live_count));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.status !== want.status) begin
               log_error($sformatf("response %0d status: expected %0d, got %0d",
                                   checked_count, want.status, rsp_ch.status));
            end
            if (rsp_ch.live_count !== want.live_count) begin
               log_error($sformatf("response %0d live count: expected %0d, got %0d",
                                   checked_count, want.live_count, rsp_ch.live_count));
            end
         end
      end
   end

   // extremes of key and value, update, remove hit and miss
   task automatic test_basic_ops();
      send_request(OP_INSERT, '0, 32'h7FFF_FFFF);
      send_request(OP_INSERT, '1, 32'h8000_0000);
      send_request(OP_INSERT, '0, '0);
      send_request(OP_REMOVE, '0, '1);
      // home slot is a tombstone, next slot empty
      send_request(OP_REMOVE, '0, '0);
      // home slot never used
      send_request(OP_REMOVE, 31'd5, 32'h5555_5555);
   endtask

   // colliding keys, reuse of a tombstone ahead of the key so it appears twice
   task automatic test_tombstone_reuse();
      send_request(OP_INSERT, 31'd3, 32'hAAAA_AAAA);
      send_request(OP_INSERT, 31'd19, 32'h5555_5555);
      send_request(OP_REMOVE, 31'd3, '0);
      send_request(OP_INSERT, 31'd19, 32'h0000_0001);
      send_request(OP_REMOVE, 31'd19, '0);
      send_request(OP_REMOVE, 31'd19, '0);
   endtask

   // fill every slot, then insert into a full table and remove after a full lap
   task automatic test_full_table();
      int j;
      for (j = 0; j < TABLE_SLOTS - 1; j++) begin
         send_request(OP_INSERT, 31'(j * 17 + 32), $urandom);
      end
      send_request(OP_INSERT, 31'h2AAA_AAAA, 32'hFFFF_FFFF);
      send_request(OP_INSERT, '1, 32'h7FFF_FFFF);
      send_request(OP_REMOVE, 31'h5555_5555, '0);
   endtask

   // random mix over a small key pool so that hits, collisions and tombstones are common
   task automatic test_random_mix(input int items, input int insert_pct, input int pool_n);
      logic [KEY_W-1:0] pool [32];
      logic [KEY_W-1:0] k;
      logic             op;
      int               i;
      for (i = 0; i < 32; i++) begin
         pool[i] = 31'($urandom);
         // half the pool crowds into a few home slots
         if (i % 2 == 1) begin
            pool[i][3:0] = 4'($urandom_range(0, 3));
         end
      end
      for (i = 0; i < items; i++) begin
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         // a few keys from anywhere in the range
         k = ($urandom_range(99) < 8) ? 31'($urandom) : pool[$urandom_range(0, pool_n - 1)];
         send_request(op, k, $urandom);
      end
   endtask

   // long stretch with both sides running flat out
   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random_mix(250, 55, 20);
      idle_on = 1'b1;
   endtask

   initial begin
      idle_on       = 1'b1;
      error_count   = 0;
      sent_count    = 0;
      checked_count = 0;
      shadow_live   = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      foreach (shadow_mark[i]) begin
         shadow_mark[i]  = MARK_EMPTY;
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
      end

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= OP_INSERT;
      req_ch.key       <= '0;
      req_ch.value     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_tombstone_reuse();
      test_full_table();
      // fill level wanders from full down to sparse and back
      test_random_mix(250, 45, 24);
      test_random_mix(250, 60, 20);
      test_random_mix(250, 75, 32);
      test_back_to_back();
      test_random_mix(250, 30, 24);
      test_random_mix(250, 50, 12);
      test_random_mix(250, 65, 28);

      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      // let any stray response show up
      repeat (40) @(posedge clock);

      $display("tb_top: %0d requests sent, %0d responses checked, %0d errors",
               sent_count, checked_count, error_count);
      $display("tb_top: inserted %0d, updated %0d, full %0d, removed %0d, not found %0d",
               status_tally[ST_INSERTED], status_tally[ST_UPDATED], status_tally[ST_FULL],
               status_tally[ST_REMOVED], status_tally[ST_MISSING]);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/lpht_pkg.sv
rtl/lpht_req_if.sv
rtl/lpht_rsp_if.sv
rtl/lpht_sequencer.sv
rtl/lpht_datapath.sv
rtl/linear_probe_hash_table.sv
tb/tb_top.sv
